// ----- design/pmap_pkg.sv -----
// Shared types and constants for the page map lookup-or-allocate core.
package pmap_pkg;

    localparam int PMAP_BUCKETS   = 1024;
    localparam int PMAP_SLOTS     = 1024;
    localparam int PMAP_QDEPTH    = 4;
    localparam int PN_W           = 32;
    localparam int SLOT_OUT_W     = 10;
    localparam int COUNT_OUT_W    = 11;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HEAD,
        ST_CMP,
        ST_MISS,
        ST_RESP
    } back_state_t;

    typedef struct packed {
        logic                   hit;
        logic [SLOT_OUT_W-1:0]  slot;
        logic                   full_res;
        logic [COUNT_OUT_W-1:0] alloc_count;
    } pmap_res_t;

endpackage

// ----- design/pmap_front.sv -----
// Front end: accepts page numbers and registers each one with its bucket index.
module pmap_front import pmap_pkg::*; #(
    parameter int BUCKETS = PMAP_BUCKETS,
    parameter int BKT_W   = $clog2(BUCKETS)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             enable,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [PN_W-1:0]  in_pn,
    output logic             q_valid,
    input  logic             q_ready,
    output logic [PN_W-1:0]  q_pn,
    output logic [BKT_W-1:0] q_bkt
);

    // BUCKETS is a power of two, so the bucket is the low bits of the page number.
    logic [PN_W-1:0]  pn_reg;
    logic [BKT_W-1:0] bkt_reg;
    logic             vld_reg;
    logic             adv;
    logic             take;

    assign adv      = !vld_reg || q_ready;
    assign in_ready = adv && enable;
    assign take     = in_valid && in_ready;
    assign q_valid  = vld_reg;
    assign q_pn     = pn_reg;
    assign q_bkt    = bkt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg <= take;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            pn_reg  <= in_pn;
            bkt_reg <= in_pn[BKT_W-1:0];
        end
    end

endmodule

// ----- design/pmap_fifo.sv -----
// Small first-in first-out queue between the front end and the lookup engine.
module pmap_fifo import pmap_pkg::*; #(
    parameter int WIDTH = PN_W,
    parameter int DEPTH = PMAP_QDEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_ready,
    output logic [WIDTH-1:0] rd_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wp_reg, rp_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             push, pop;

    assign wr_ready = cnt_reg != CNT_W'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_data  = store_reg[rp_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wp_reg <= (wp_reg == PTR_W'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= (rp_reg == PTR_W'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wp_reg] <= wr_data;
        end
    end

endmodule

// ----- design/pmap_back.sv -----
// Lookup engine: walks bucket chains in the maps and allocates slots on a miss.
module pmap_back import pmap_pkg::*; #(
    parameter int BUCKETS = PMAP_BUCKETS,
    parameter int SLOTS   = PMAP_SLOTS,
    parameter int BKT_W   = $clog2(BUCKETS),
    parameter int SLOT_W  = $clog2(SLOTS),
    parameter int CNT_W   = $clog2(SLOTS + 1)
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_pop,
    input  logic [PN_W-1:0]  q_pn,
    input  logic [BKT_W-1:0] q_bkt,
    input  logic             out_free,
    output logic             res_valid,
    output pmap_res_t        res,
    output logic             clear_done
);

    back_state_t state_reg, state_next;

    logic [PN_W-1:0]   pn_reg;
    logic [BKT_W-1:0]  bkt_reg;
    logic [SLOT_W:0]   head_reg;
    logic [SLOT_W-1:0] cur_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [BKT_W-1:0]  clr_reg;
    logic              res_hit_reg, res_full_reg;
    logic [SLOT_W-1:0] res_slot_reg;

    // Bucket heads carry a valid bit on top; slot links likewise.
    logic [SLOT_W:0]   bkt_mem [BUCKETS];
    logic [PN_W-1:0]   pn_mem  [SLOTS];
    logic [SLOT_W:0]   nxt_mem [SLOTS];
    logic [SLOT_W:0]   bkt_rd_reg;
    logic [PN_W-1:0]   pn_rd_reg;
    logic [SLOT_W:0]   nxt_rd_reg;

    logic              bkt_we;
    logic [BKT_W-1:0]  bkt_wa;
    logic [SLOT_W:0]   bkt_wd;
    logic              slot_we;
    logic [SLOT_W-1:0] slot_ra;
    logic              match, is_full;

    assign match   = pn_rd_reg == pn_reg;
    assign is_full = count_reg == CNT_W'(SLOTS);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (clr_reg == BKT_W'(BUCKETS - 1)) state_next = ST_IDLE;
            ST_IDLE:  if (q_valid) state_next = ST_HEAD;
            ST_HEAD:  state_next = bkt_rd_reg[SLOT_W] ? ST_CMP : ST_MISS;
            ST_CMP: begin
                if (match) begin
                    state_next = ST_RESP;
                end else if (!nxt_rd_reg[SLOT_W]) begin
                    state_next = ST_MISS;
                end
            end
            ST_MISS:  state_next = ST_RESP;
            ST_RESP:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        q_pop      = state_reg == ST_IDLE;
        res_valid  = state_reg == ST_RESP;
        clear_done = state_reg != ST_CLEAR;
        bkt_we     = 1'b0;
        bkt_wa     = bkt_reg;
        bkt_wd     = {1'b1, count_reg[SLOT_W-1:0]};
        slot_we    = 1'b0;
        slot_ra    = cur_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                bkt_we = 1'b1;
                bkt_wa = clr_reg;
                bkt_wd = '0;
            end
            ST_HEAD:  slot_ra = bkt_rd_reg[SLOT_W-1:0];
            ST_CMP:   slot_ra = nxt_rd_reg[SLOT_W-1:0];
            ST_MISS: begin
                bkt_we  = !is_full;
                slot_we = !is_full;
            end
            default: begin
            end
        endcase
    end

    assign res.hit         = res_hit_reg;
    assign res.slot        = SLOT_OUT_W'(res_slot_reg);
    assign res.full_res    = res_full_reg;
    assign res.alloc_count = COUNT_OUT_W'(count_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            clr_reg   <= '0;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_CLEAR) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (state_reg == ST_MISS && !is_full) begin
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE) begin
            pn_reg  <= q_pn;
            bkt_reg <= q_bkt;
        end
        if (state_reg == ST_HEAD) begin
            head_reg <= bkt_rd_reg;
        end
        if (state_reg == ST_HEAD || state_reg == ST_CMP) begin
            cur_reg <= slot_ra;
        end
        if (state_reg == ST_CMP && match) begin
            res_hit_reg  <= 1'b1;
            res_full_reg <= 1'b0;
            res_slot_reg <= cur_reg;
        end
        if (state_reg == ST_MISS) begin
            res_hit_reg  <= 1'b0;
            res_full_reg <= is_full;
            res_slot_reg <= is_full ? '0 : count_reg[SLOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (bkt_we) begin
            bkt_mem[bkt_wa] <= bkt_wd;
        end
        bkt_rd_reg <= bkt_mem[q_bkt];
    end

    always_ff @(posedge aclk) begin
        if (slot_we) begin
            pn_mem[count_reg[SLOT_W-1:0]]  <= pn_reg;
            nxt_mem[count_reg[SLOT_W-1:0]] <= head_reg;
        end
        pn_rd_reg  <= pn_mem[slot_ra];
        nxt_rd_reg <= nxt_mem[slot_ra];
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(SLOTS))
        else $error("allocation count exceeds the slot count");

    a_full_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        res_valid && res_full_reg |-> is_full && !res_hit_reg)
        else $error("full result while slots remain");

    a_cmp_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CMP |-> $past(state_reg) == ST_HEAD || $past(state_reg) == ST_CMP)
        else $error("chain compare entered without a slot read");

    a_no_pop_in_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !(q_pop && q_valid) && count_reg == '0)
        else $error("activity during the bucket clearing pass");

endmodule

// ----- design/page_map_lookup_or_allocate_core.sv -----
// Top level of the page map core: front end, queue, lookup engine and result register.
//
//  Channel  Direction  Ports                     Contents
//  s_       in         s_tvalid/s_tready/s_tdata page_number
//  m_       out        m_tvalid/m_tready/m_tdata slot, alloc_count; m_tuser: hit, full_res
//
// The front end registers each page number together with its bucket index, which is the
// low bits of the number since BUCKETS is a power of two, and takes a new item every cycle
// while the queue has room. The lookup engine takes one item at a time: it pops it while
// idle, reads the bucket head, compares the page with each chain link that it follows or
// allocates a free slot on a miss, and holds its result until the output register is free.
// After reset the engine clears the bucket-head memory, one entry per cycle, and s_tready
// stays low until that pass ends.
// A result waits in the output register; the engine stalls only when a second
// result is ready while the first is still held, and the queue absorbs the front end.
module page_map_lookup_or_allocate_core import pmap_pkg::*; #(
    parameter int BUCKETS = PMAP_BUCKETS,
    parameter int SLOTS   = PMAP_SLOTS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] page_number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [9:0] slot, [20:10] alloc_count, [23:21] zero
    output logic [1:0]  m_tuser    // [0] hit, [1] full_res
);

    localparam int BKT_W  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int CNT_W  = $clog2(SLOTS + 1);

    // Front end to queue.
    logic             f_valid, f_ready;
    logic [PN_W-1:0]  f_pn;
    logic [BKT_W-1:0] f_bkt;

    // Queue to lookup engine; the entry carries the page number above its bucket.
    logic                  b_valid, b_pop;
    logic [PN_W+BKT_W-1:0] b_data;

    logic      clear_done;
    logic      res_valid, out_free;
    pmap_res_t res;

    logic      m_tvalid_reg;
    pmap_res_t out_reg;

    pmap_front #(
        .BUCKETS (BUCKETS),
        .BKT_W   (BKT_W)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .enable   (clear_done),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_pn    (s_tdata),
        .q_valid  (f_valid),
        .q_ready  (f_ready),
        .q_pn     (f_pn),
        .q_bkt    (f_bkt)
    );

    pmap_fifo #(
        .WIDTH (PN_W + BKT_W),
        .DEPTH (PMAP_QDEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  ({f_pn, f_bkt}),
        .rd_valid (b_valid),
        .rd_ready (b_pop),
        .rd_data  (b_data)
    );

    pmap_back #(
        .BUCKETS (BUCKETS),
        .SLOTS   (SLOTS),
        .BKT_W   (BKT_W),
        .SLOT_W  (SLOT_W),
        .CNT_W   (CNT_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (b_valid),
        .q_pop      (b_pop),
        .q_pn       (b_data[PN_W+BKT_W-1:BKT_W]),
        .q_bkt      (b_data[BKT_W-1:0]),
        .out_free   (out_free),
        .res_valid  (res_valid),
        .res        (res),
        .clear_done (clear_done)
    );

    // The output register is free when empty or when its item leaves this cycle.
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_free) begin
            m_tvalid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, out_reg.alloc_count, out_reg.slot};
    assign m_tuser  = {out_reg.full_res, out_reg.hit};

endmodule

// ----- sim/page_map_lookup_or_allocate_core_tb.sv -----
// Testbench for the page map core: directed and random page lookups checked by a predictor.
`timescale 1ns / 1ps

module page_map_lookup_or_allocate_core_tb;
    import pmap_pkg::*;

    // The run is ended by force after this many clock cycles.
    localparam int CYCLE_LIMIT = 1000000;
    // Items accepted before the receiver's long hold-off starts.
    localparam int HOLD_AFTER_ITEMS = 300;
    localparam int HOLD_CYCLES = 400;
    // Items sent once the table is full: repeats that hit and new pages that hit the full case.
    localparam int ITEMS_AFTER_FULL = 40;
    // Quiet cycles at the end; any late result in this window is unexpected.
    localparam int DRAIN_CYCLES = 60;

    // One row of the directed table. When has_expect is set the expected result is the one
    // typed into the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic [PN_W-1:0] page;
        bit              has_expect;
        pmap_res_t       res;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 17;

    // Rows run in order from reset. Fields of res are hit, slot, full_res, alloc_count.
    // Pages 0x000, 0x400, 0xFFFFFC00 and 0x80000000 share bucket 0, and 0xFFFFFFFF, 0x3FF and
    // 0x7FFFFFFF share bucket 1023, so the rows walk chains to their head, middle and tail.
    directed_row_t directed_rows [DIRECTED_ROWS] = '{
        '{32'h0000_0000, 1'b1, '{1'b0, 10'd0, 1'b0, 11'd1}},
        '{32'h0000_0000, 1'b1, '{1'b1, 10'd0, 1'b0, 11'd1}},
        '{32'hFFFF_FFFF, 1'b1, '{1'b0, 10'd1, 1'b0, 11'd2}},
        '{32'h0000_0400, 1'b1, '{1'b0, 10'd2, 1'b0, 11'd3}},
        '{32'hFFFF_FC00, 1'b1, '{1'b0, 10'd3, 1'b0, 11'd4}},
        '{32'h8000_0000, 1'b1, '{1'b0, 10'd4, 1'b0, 11'd5}},
        '{32'h0000_0000, 1'b1, '{1'b1, 10'd0, 1'b0, 11'd5}},
        '{32'h0000_0400, 1'b1, '{1'b1, 10'd2, 1'b0, 11'd5}},
        '{32'h0000_03FF, 1'b1, '{1'b0, 10'd5, 1'b0, 11'd6}},
        '{32'h7FFF_FFFF, 1'b1, '{1'b0, 10'd6, 1'b0, 11'd7}},
        '{32'hFFFF_FFFF, 1'b1, '{1'b1, 10'd1, 1'b0, 11'd7}},
        '{32'h0000_0001, 1'b1, '{1'b0, 10'd7, 1'b0, 11'd8}},
        '{32'hAAAA_AAAA, 1'b0, '0},
        '{32'h5555_5555, 1'b0, '0},
        '{32'hFFFF_FC00, 1'b1, '{1'b1, 10'd3, 1'b0, 11'd10}},
        '{32'h8000_0000, 1'b1, '{1'b1, 10'd4, 1'b0, 11'd10}},
        '{32'h0000_0001, 1'b1, '{1'b1, 10'd7, 1'b0, 11'd10}}
    };

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;

    page_map_lookup_or_allocate_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] page_number
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [9:0] slot, [20:10] alloc_count, [23:21] zero
        .m_tuser  (m_tuser)    // [0] hit, [1] full_res
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Our own copy of the page map: bucket heads, per-slot page numbers and chain links.
    bit                    head_valid   [PMAP_BUCKETS];
    logic [SLOT_OUT_W-1:0] head_slot    [PMAP_BUCKETS];
    logic [PN_W-1:0]       page_of_slot [PMAP_SLOTS];
    bit                    link_valid   [PMAP_SLOTS];
    logic [SLOT_OUT_W-1:0] link_slot    [PMAP_SLOTS];
    int unsigned           slots_used = 0;

    pmap_res_t   pending_results [$];   // expected results in the order items were accepted
    logic [31:0] sent_pages      [$];   // every page sent so far, the pool for repeat lookups
    int          mismatch_count  = 0;
    int          items_accepted  = 0;
    int          cycle_count     = 0;
    int          burst_left      = 0;
    logic        hold_off        = 1'b0;

    // Walk the page's bucket chain. A match is a hit; otherwise the next free slot is taken
    // and pushed onto the head of the chain, unless every slot is already in use.
    function automatic pmap_res_t lookup_or_allocate(input logic [PN_W-1:0] page);
        int unsigned bucket;
        int unsigned slot;
        int unsigned steps;
        bit          walk_valid;
        bit          found;
        pmap_res_t   res;
        bucket     = page % PMAP_BUCKETS;
        walk_valid = head_valid[bucket];
        slot       = head_slot[bucket];
        steps      = 0;
        found      = 1'b0;
        res        = '0;
        while (walk_valid && !found && steps < PMAP_SLOTS) begin
            if (page_of_slot[slot] == page) begin
                found = 1'b1;
            end else begin
                walk_valid = link_valid[slot];
                slot       = link_slot[slot];
                steps++;
            end
        end
        if (found) begin
            res.hit  = 1'b1;
            res.slot = SLOT_OUT_W'(slot);
        end else if (slots_used >= PMAP_SLOTS) begin
            res.full_res = 1'b1;
        end else begin
            slot               = slots_used;
            page_of_slot[slot] = page;
            link_valid[slot]   = head_valid[bucket];
            link_slot[slot]    = head_slot[bucket];
            head_valid[bucket] = 1'b1;
            head_slot[bucket]  = SLOT_OUT_W'(slot);
            slots_used++;
            res.slot = SLOT_OUT_W'(slot);
        end
        res.alloc_count = COUNT_OUT_W'(slots_used);
        return res;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    // Offers one page and waits for the handshake. The sender works in bursts: when a burst
    // runs out it may drop tvalid for a random gap (with junk on tdata) before the next one.
    // A gap of zero keeps tvalid high across bursts, so some stretches have no idling at all.
    task automatic send_item(input logic [31:0] page, input bit has_expect,
                             input pmap_res_t typed_res);
        int        gap;
        pmap_res_t predicted;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= $urandom();
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= page;
        do @(posedge aclk); while (!s_tready);
        // The item was taken at this edge; the predictor sees items in the same order.
        predicted = lookup_or_allocate(page);
        pending_results.push_back(has_expect ? typed_res : predicted);
        sent_pages.push_back(page);
        items_accepted++;
    endtask

    // A page not seen before, with good odds. About a third land in eight hot buckets so
    // that some chains grow long and lookups have to follow many links.
    function automatic logic [31:0] fresh_page();
        logic [31:0] page;
        page = $urandom();
        if ($urandom_range(0, 99) < 30) begin
            page[9:0] = 10'($urandom_range(0, 7));
        end
        return page;
    endfunction

    function automatic logic [31:0] known_page();
        return sent_pages[$urandom_range(0, sent_pages.size() - 1)];
    endfunction

    // Receiver: m_tready follows a mode that is redrawn at random: always ready,
    // a coin toss each cycle, or ready only one cycle in four. The long hold-off overrides it.
    int ready_mode      = 0;
    int ready_mode_left = 0;
    always @(posedge aclk) begin
        if (ready_mode_left == 0) begin
            ready_mode      = $urandom_range(0, 2);
            ready_mode_left = $urandom_range(5, 60);
        end
        ready_mode_left--;
        case (ready_mode)
            0: begin
                m_tready <= !hold_off;
            end
            1: begin
                m_tready <= !hold_off && ($urandom_range(0, 1) == 1);
            end
            default: begin
                m_tready <= !hold_off && ($urandom_range(0, 3) == 0);
            end
        endcase
    end

    // Once the run is under way, the receiver holds off for a long stretch while the sender
    // keeps offering items. The output register, queue and front end fill and s_tready drops.
    initial begin
        wait (items_accepted >= HOLD_AFTER_ITEMS);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        hold_off <= 1'b0;
    end

    // Result checker: every accepted result is compared with the oldest expectation.
    always @(posedge aclk) begin
        pmap_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending, m_tdata", m_tdata, 0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.hit)
                    report_mismatch("hit", m_tuser[0], want.hit);
                if (m_tdata[9:0] !== want.slot)
                    report_mismatch("slot", m_tdata[9:0], want.slot);
                if (m_tuser[1] !== want.full_res)
                    report_mismatch("full_res", m_tuser[1], want.full_res);
                if (m_tdata[20:10] !== want.alloc_count)
                    report_mismatch("alloc_count", m_tdata[20:10], want.alloc_count);
                if (m_tdata[23:21] !== 3'b000)
                    report_mismatch("tdata padding", m_tdata[23:21], 0);
            end
        end
    end

    // Watchdog. The limit covers the bucket-head clearing pass after reset, long chain walks,
    // the hold-off and both sides' idling with a wide margin.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        // Hold reset first; s_tready stays low after that until the clearing pass ends,
        // which the first handshake simply waits out.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            send_item(directed_rows[i].page, directed_rows[i].has_expect, directed_rows[i].res);
        end

        // Fill the table with mostly new pages and a few repeats, then keep going past full:
        // repeats must still hit, and new pages must come back with full_res set.
        while (slots_used < PMAP_SLOTS) begin
            send_item(($urandom_range(0, 99) < 95) ? fresh_page() : known_page(), 1'b0, '0);
        end
        repeat (ITEMS_AFTER_FULL) begin
            send_item(($urandom_range(0, 99) < 60) ? known_page() : fresh_page(), 1'b0, '0);
        end

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
